// ----- rtl/i2cbb_pkg.sv -----
// Package: shared types and constants for the bit-banged I2C master.
package i2cbb_pkg;

   localparam int DATA_BITS         = 8;
   localparam int DELAY_W           = 16;
   localparam int CSR_INDEX_W       = 2;
   localparam int I2CBB_QUEUE_DEPTH = 4;

   // Input opcodes
   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_START = 3'd1;
   localparam logic [2:0] OP_STOP  = 3'd2;
   localparam logic [2:0] OP_WRITE = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BIT_DELAY   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_READ_TAIL   = 2'd2;

   localparam logic [DELAY_W-1:0] SHORT_DELAY_RESET = 16'd5;
   localparam logic [DELAY_W-1:0] BIT_DELAY_RESET   = 16'd50;
   localparam logic [DELAY_W-1:0] READ_TAIL_RESET   = 16'd2000;

   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [DATA_BITS-1:0]  data_byte;
      logic                  send_ack;
      logic                  sda_in;
   } item_type;

   typedef struct packed {
      logic                  scl_level;
      logic                  sda_level;
      logic                  sda_drive;
      logic                  busy_res;
      logic                  done_res;
      logic [DATA_BITS-1:0]  rx_byte;
      logic                  ack_seen;
      logic                  cmd_rejected;
   } result_type;

endpackage

// ----- rtl/i2cbb_if.sv -----
// Interfaces: request and response channels of the I2C master.
interface i2cbb_req_if import i2cbb_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [2:0]           opcode;
   logic [DATA_BITS-1:0] data_byte;
   logic                 send_ack;
   logic                 sda_in;

   modport source (output valid, output opcode, output data_byte, output send_ack,
                   output sda_in, input ready);
   modport sink   (input valid, input opcode, input data_byte, input send_ack,
                   input sda_in, output ready);
endinterface

interface i2cbb_rsp_if import i2cbb_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 scl_level;
   logic                 sda_level;
   logic                 sda_drive;
   logic                 busy_res;
   logic                 done_res;
   logic [DATA_BITS-1:0] rx_byte;
   logic                 ack_seen;
   logic                 cmd_rejected;

   modport source (output valid, output scl_level, output sda_level, output sda_drive,
                   output busy_res, output done_res, output rx_byte, output ack_seen,
                   output cmd_rejected, input ready);
   modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                   input busy_res, input done_res, input rx_byte, input ack_seen,
                   input cmd_rejected, output ready);
endinterface

// ----- rtl/i2cbb_front.sv -----
// Front end: accepts request beats and classifies the opcode.
module i2cbb_front import i2cbb_pkg::*; (
   i2cbb_req_if.sink req_ch,
   input  logic      queue_full,
   output logic      push,
   output item_type  push_item
);

   kind_type kind;

   always_comb begin
      case (req_ch.opcode)
         OP_START: kind = KIND_START;
         OP_STOP:  kind = KIND_STOP;
         OP_WRITE: kind = KIND_WRITE;
         OP_READ:  kind = KIND_READ;
         default:  kind = KIND_TICK;
      endcase
   end

   assign req_ch.ready        = !queue_full;
   assign push                = req_ch.valid && !queue_full;
   assign push_item.kind      = kind;
   assign push_item.data_byte = req_ch.data_byte;
   assign push_item.send_ack  = req_ch.send_ack;
   assign push_item.sda_in    = req_ch.sda_in;

endmodule

// ----- rtl/i2cbb_queue.sv -----
// Queue: short FIFO of classified items between front end and sequencer.
module i2cbb_queue import i2cbb_pkg::*; #(
   parameter int DEPTH = I2CBB_QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output logic     full,
   output logic     not_empty,
   output item_type head_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(DEPTH) && !pop) |=> count_ff == CNT_W'(DEPTH))
      else $error("queue lost an entry while full");

endmodule

// ----- rtl/i2cbb_seq.sv -----
// Sequencer: steps the SCL/SDA state machine once per item and registers the result.
module i2cbb_seq import i2cbb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DELAY_W-1:0]     csr_wdata,
   input  logic                   item_valid,
   input  item_type               item,
   output logic                   pop,
   i2cbb_rsp_if.source            rsp_ch
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_START, PH_STOP, PH_W_DATA, PH_W_HIGH, PH_W_LOW, PH_W_ACK,
      PH_W_END, PH_R_HIGH, PH_R_LOW, PH_R_ACK, PH_R_TAIL
   } phase_type;

   localparam logic [3:0] BITS_LIMIT = 4'(DATA_BITS);

   phase_type            phase_ff, phase_in;
   logic [3:0]           bit_count_ff, bit_count_in;
   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [DELAY_W-1:0]   delay_ff, delay_in;
   logic                 ack_req_ff, ack_req_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic                 sda_oe_ff, sda_oe_in;
   logic                 ack_ff, ack_in;
   logic [DATA_BITS-1:0] rx_ff, rx_in;
   logic [DELAY_W-1:0]   short_ff, bit_ff, tail_ff;
   logic                 rsp_valid_ff;
   result_type           res_ff, res_in;
   logic                 step;
   logic                 is_cmd;
   logic                 done;
   logic                 rejected;

   // advance whenever an item is waiting and the output slot is free or being drained
   assign step   = item_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign pop    = step;
   assign is_cmd = (item.kind != KIND_TICK);

   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      ack_req_in   = ack_req_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      sda_oe_in    = sda_oe_ff;
      ack_in       = ack_ff;
      rx_in        = rx_ff;
      done         = 1'b0;
      rejected     = 1'b0;

      if (is_cmd && phase_ff == PH_IDLE) begin
         case (item.kind)
            KIND_START: begin
               sda_oe_in = 1'b1; scl_in = 1'b1; sda_in = 1'b1;
               phase_in  = PH_START; delay_in = bit_ff;
            end
            KIND_STOP: begin
               sda_oe_in = 1'b1; scl_in = 1'b1; sda_in = 1'b0;
               phase_in  = PH_STOP; delay_in = bit_ff;
            end
            KIND_WRITE: begin
               scl_in       = 1'b0;
               shift_in     = item.data_byte;
               bit_count_in = '0;
               sda_in       = item.data_byte[DATA_BITS-1];
               phase_in     = PH_W_DATA; delay_in = '0;
            end
            default: begin
               sda_oe_in    = 1'b0;
               shift_in     = '0;
               bit_count_in = '0;
               ack_req_in   = item.send_ack;
               scl_in       = 1'b1;
               phase_in     = PH_R_HIGH; delay_in = short_ff;
            end
         endcase
      end else begin
         rejected = is_cmd;
         if (phase_ff != PH_IDLE) begin
            if (delay_ff != '0) begin
               delay_in = delay_ff - DELAY_W'(1);
            end else begin
               case (phase_ff)
                  PH_START: begin
                     sda_in = 1'b0; phase_in = PH_IDLE; done = 1'b1;
                  end
                  PH_STOP: begin
                     sda_in = 1'b1; phase_in = PH_IDLE; done = 1'b1;
                  end
                  PH_W_DATA: begin
                     scl_in = 1'b1; phase_in = PH_W_HIGH; delay_in = bit_ff;
                  end
                  PH_W_HIGH: begin
                     scl_in       = 1'b0;
                     shift_in     = {shift_ff[DATA_BITS-2:0], 1'b0};
                     bit_count_in = bit_count_ff + 4'd1;
                     phase_in     = PH_W_LOW; delay_in = bit_ff;
                  end
                  PH_W_LOW: begin
                     delay_in = '0;
                     if (bit_count_ff >= BITS_LIMIT) begin
                        // release SDA for the slave's ACK clock
                        sda_in = 1'b0; sda_oe_in = 1'b0; scl_in = 1'b1;
                        phase_in = PH_W_ACK;
                     end else begin
                        sda_in   = shift_ff[DATA_BITS-1];
                        phase_in = PH_W_DATA;
                     end
                  end
                  PH_W_ACK: begin
                     ack_in   = !item.sda_in;
                     scl_in   = 1'b0;
                     phase_in = PH_W_END; delay_in = '0;
                  end
                  PH_W_END: begin
                     sda_oe_in = 1'b1; phase_in = PH_IDLE; done = 1'b1;
                  end
                  PH_R_HIGH: begin
                     shift_in     = {shift_ff[DATA_BITS-2:0], item.sda_in};
                     scl_in       = 1'b0;
                     bit_count_in = bit_count_ff + 4'd1;
                     phase_in     = PH_R_LOW; delay_in = bit_ff;
                  end
                  PH_R_LOW: begin
                     if (bit_count_ff < BITS_LIMIT) begin
                        scl_in   = 1'b1;
                        phase_in = PH_R_HIGH; delay_in = short_ff;
                     end else begin
                        rx_in = shift_ff;
                        if (ack_req_ff) begin
                           sda_oe_in = 1'b1; sda_in = 1'b0; scl_in = 1'b1;
                           phase_in  = PH_R_ACK; delay_in = bit_ff;
                        end else begin
                           phase_in = PH_R_TAIL; delay_in = tail_ff;
                        end
                     end
                  end
                  PH_R_ACK: begin
                     scl_in   = 1'b0;
                     phase_in = PH_R_TAIL; delay_in = tail_ff;
                  end
                  PH_R_TAIL: begin
                     phase_in = PH_IDLE; done = 1'b1;
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         end
      end

      res_in.scl_level    = scl_in;
      res_in.sda_level    = sda_in;
      res_in.sda_drive    = sda_oe_in;
      res_in.busy_res     = (phase_in != PH_IDLE);
      res_in.done_res     = done;
      res_in.rx_byte      = rx_in;
      res_in.ack_seen     = ack_in;
      res_in.cmd_rejected = rejected;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         delay_ff     <= '0;
         ack_req_ff   <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         sda_oe_ff    <= 1'b1;
         ack_ff       <= 1'b0;
         rx_ff        <= '0;
         short_ff     <= SHORT_DELAY_RESET;
         bit_ff       <= BIT_DELAY_RESET;
         tail_ff      <= READ_TAIL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (step) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            delay_ff     <= delay_in;
            ack_req_ff   <= ack_req_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            sda_oe_ff    <= sda_oe_in;
            ack_ff       <= ack_in;
            rx_ff        <= rx_in;
            res_ff       <= res_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_SHORT_DELAY: short_ff <= csr_wdata;
               CSR_BIT_DELAY:   bit_ff   <= csr_wdata;
               CSR_READ_TAIL:   tail_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.scl_level    = res_ff.scl_level;
   assign rsp_ch.sda_level    = res_ff.sda_level;
   assign rsp_ch.sda_drive    = res_ff.sda_drive;
   assign rsp_ch.busy_res     = res_ff.busy_res;
   assign rsp_ch.done_res     = res_ff.done_res;
   assign rsp_ch.rx_byte      = res_ff.rx_byte;
   assign rsp_ch.ack_seen     = res_ff.ack_seen;
   assign rsp_ch.cmd_rejected = res_ff.cmd_rejected;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && res_ff.done_res) |-> !res_ff.busy_res)
      else $error("done reported while sequence still busy");

   a_delay_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(delay_ff) && $stable(phase_ff))
      else $error("sequencer moved without an item");

   a_read_start: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_IDLE && item.kind == KIND_READ)
      |=> (phase_ff == PH_R_HIGH && !sda_oe_ff && scl_ff))
      else $error("read command did not release SDA");

endmodule

// ----- rtl/i2c_bitbang_master.sv -----
// Top level: bit-banged I2C master with decoupled front end and sequencer.
//
//  channel   dir  handshake            payload
//  req_ch    in   valid/ready          opcode, data_byte, send_ack, sda_in
//  rsp_ch    out  valid/ready          scl/sda levels, status, rx_byte, ack
//  csr_*     in   csr_we, no back-off  csr_index, csr_wdata (16 bits)
//
// One item per clock sustained while rsp_ch is ready; each result passes from its beat
// through the queue and then the output register.
// The sequencer steps once per item, so the output register sets the pace.
// Synchronous active-high reset restores the idle bus and reset delays.
// A stalled response holds the sequencer; the queue then fills and drops ready.
module i2c_bitbang_master import i2cbb_pkg::*; #(
   parameter int QUEUE_DEPTH = I2CBB_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   i2cbb_req_if.sink              req_ch,
   i2cbb_rsp_if.source            rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DELAY_W-1:0]     csr_wdata
);

   logic     push;
   logic     pop;
   logic     queue_full;
   logic     queue_not_empty;
   item_type push_item;
   item_type head_item;

   i2cbb_front u_front (
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   i2cbb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head_item (head_item)
   );

   i2cbb_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (queue_not_empty),
      .item       (head_item),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
